// ===== src/fspd_pkg.sv =====
// shared types and constants of the palette dither unit
`default_nettype none

package fspd_pkg;

   // default sizes
   localparam int MAX_WIDTH_DEF     = 1024;
   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int ERROR_LIMIT_DEF   = 20;

   // colour cache: 5 bits per channel key, entry holds index plus one
   localparam int CACHE_DEPTH = 32768;
   localparam int CACHE_AW    = 15;
   localparam int CACHE_DW    = 9;

   // search start value and csr data width
   localparam logic [19:0] BEST_INIT  = 20'd1000000;
   localparam int          CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_PIXEL = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_PSIZE  = 2'd2,
      CSR_DITHER = 2'd3
   } csr_type;

   typedef enum logic [3:0] {
      ST_CLR,
      ST_IDLE,
      ST_ROWCLR,
      ST_ERD,
      ST_EADJ,
      ST_CRD,
      ST_SRCH,
      ST_CWR,
      ST_PRD,
      ST_EVAL,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_OUT
   } state_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  entry_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } req_type;

   typedef struct packed {
      logic [7:0]  palette_index;
      logic [9:0]  column;
      logic        row_end;
      logic        image_end;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/fspd_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none

module fspd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ===== src/floyd_steinberg_palette_dither_unit.sv =====
// palette quantiser with serpentine floyd-steinberg error diffusion
//
// Requests arrive on req_valid/req_stall with a req_type payload: load a
// palette entry, start an image (clears cache and error rows) or one pixel.
// Each pixel gives one result on rsp_valid/rsp_stall; other requests give
// none. Registers are written on the csr port (always ready); the user must
// write them only while idle, since the block itself does not enforce it.
// A palette load or an ignored operation is taken in the idle state. A pixel
// reads its error and colour cache entry; on a cache miss it runs the
// nearest colour search over the palette and fills the cache; with dithering
// on it diffuses the error to four neighbours, and at the start of each row
// it first clears the next error row. All of it runs through one sequencer
// that drives a single read port on each of the palette, cache and error
// memories. After reset and after a start image request the block runs a
// clearing pass over the cache and error rows with req_stall high.
// A result sits in an output register; while the receiver stalls it holds,
// and the next pixel is worked on but waits before that register.
`default_nettype none

module floyd_steinberg_palette_dither_unit #(
   parameter int MAX_WIDTH     = fspd_pkg::MAX_WIDTH_DEF,
   parameter int PALETTE_DEPTH = fspd_pkg::PALETTE_DEPTH_DEF,
   parameter int ERROR_LIMIT   = fspd_pkg::ERROR_LIMIT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire fspd_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output fspd_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [fspd_pkg::CSR_DATA_W-1:0]    csr_data
);

   import fspd_pkg::*;

   localparam int ROWN = MAX_WIDTH + 2;
   localparam int ED   = 2 * ROWN;
   localparam int EA   = $clog2(ED);
   localparam int PW   = $clog2(ROWN);
   localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int PA   = $clog2(PALETTE_DEPTH);
   localparam int PI   = $clog2(PALETTE_DEPTH + 1);
   localparam int EW   = $clog2(16 * ERROR_LIMIT + 1) + 2;
   localparam int VW   = EW + 3;

   // configuration registers
   logic [10:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic [8:0]  palette_size_ff;
   logic        dither_enable_ff;

   // control state
   state_type         state_ff, state_in;
   logic [CW-1:0]     column_count_ff, column_count_in;
   logic [15:0]       row_count_ff, row_count_in;
   logic              reverse_ff, reverse_in;
   logic              rowsel_ff, rowsel_in;
   logic [CACHE_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // pixel datapath registers
   logic [7:0]        src_ff [3];
   logic [7:0]        src_in [3];
   logic [7:0]        ch_ff [3];
   logic [7:0]        ch_in [3];
   logic [CACHE_AW-1:0] key_ff, key_in;
   logic [7:0]        n_ff, n_in;
   logic signed [8:0] e_ff [3];
   logic signed [8:0] e_in [3];
   logic [1:0]        slot_ff, slot_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // search unit registers
   logic [PI-1:0]     srch_cnt_ff, srch_cnt_in;
   logic              p1_valid_ff, p1_valid_in;
   logic [7:0]        p1_idx_ff, p1_idx_in;
   logic              d_valid_ff, d_valid_in;
   logic [7:0]        d_idx_ff, d_idx_in;
   logic [19:0]       dist_ff, dist_in;
   logic [19:0]       best_ff, best_in;

   // memory ports
   logic                pal_we;
   logic [PA-1:0]       pal_waddr, pal_raddr;
   logic [23:0]         pal_wdata, pal_rdata;
   logic                cache_we;
   logic [CACHE_AW-1:0] cache_waddr, cache_raddr;
   logic [CACHE_DW-1:0] cache_wdata, cache_rdata;
   logic                err_we;
   logic [EA-1:0]       err_waddr, err_raddr;
   logic [3*EW-1:0]     err_wdata, err_rdata;

   // derived pixel position
   logic              req_go, out_go, dith, rev, last;
   logic [PW-1:0]     w_eff, col, phys, pos, np, pb, slot_pos;
   logic              slot_row;
   logic [3:0]        slot_weight;
   logic [PI-1:0]     ps_eff;
   logic [EA-1:0]     slot_addr;

   fspd_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_palette (
      .clock(clock), .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
      .raddr(pal_raddr), .rdata(pal_rdata)
   );

   fspd_ram #(.WIDTH(CACHE_DW), .DEPTH(CACHE_DEPTH)) u_cache (
      .clock(clock), .we(cache_we), .waddr(cache_waddr), .wdata(cache_wdata),
      .raddr(cache_raddr), .rdata(cache_rdata)
   );

   fspd_ram #(.WIDTH(3 * EW), .DEPTH(ED)) u_errors (
      .clock(clock), .we(err_we), .waddr(err_waddr), .wdata(err_wdata),
      .raddr(err_raddr), .rdata(err_rdata)
   );

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_go    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_go    = !rsp_valid_ff || !rsp_stall;

   // effective width, column and direction
   always_comb begin
      if (image_width_ff == 11'd0) begin
         w_eff = PW'(1);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = PW'(MAX_WIDTH);
      end else begin
         w_eff = PW'(image_width_ff);
      end
      if (PW'(column_count_ff) >= w_eff) begin
         col = w_eff - PW'(1);
      end else begin
         col = PW'(column_count_ff);
      end
      dith = dither_enable_ff;
      rev  = dith && reverse_ff;
      phys = rev ? (w_eff - PW'(1) - col) : col;
      pos  = phys + PW'(1);
      np   = rev ? (pos - PW'(1)) : (pos + PW'(1));
      pb   = rev ? (pos + PW'(1)) : (pos - PW'(1));
      last = (col == w_eff - PW'(1));
      if (32'(palette_size_ff) > 32'(PALETTE_DEPTH)) begin
         ps_eff = PI'(PALETTE_DEPTH);
      end else begin
         ps_eff = PI'(palette_size_ff);
      end
   end

   // diffusion target of the current slot
   always_comb begin
      case (slot_ff)
         2'd0: begin
            slot_row = !rowsel_ff; slot_pos = np; slot_weight = 4'd1;
         end
         2'd1: begin
            slot_row = !rowsel_ff; slot_pos = pb; slot_weight = 4'd3;
         end
         2'd2: begin
            slot_row = !rowsel_ff; slot_pos = pos; slot_weight = 4'd5;
         end
         default: begin
            slot_row = rowsel_ff; slot_pos = np; slot_weight = 4'd7;
         end
      endcase
      slot_addr = (slot_row ? EA'(ROWN) : EA'(0)) + EA'(slot_pos);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLR: begin
            if (clr_cnt_ff == CACHE_AW'(CACHE_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_go) begin
               case (req_data.operation)
                  OP_START: state_in = ST_CLR;
                  OP_PIXEL: begin
                     if (col == '0 && dith) state_in = ST_ROWCLR;
                     else state_in = ST_ERD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ROWCLR: begin
            if (clr_cnt_ff == CACHE_AW'(ROWN - 1)) state_in = ST_ERD;
         end
         ST_ERD:  state_in = ST_EADJ;
         ST_EADJ: state_in = ST_CRD;
         ST_CRD: begin
            if (cache_rdata == '0) state_in = ST_SRCH;
            else if (dith) state_in = ST_PRD;
            else state_in = ST_OUT;
         end
         ST_SRCH: begin
            if (srch_cnt_ff == ps_eff && !p1_valid_ff && !d_valid_ff) begin
               state_in = ST_CWR;
            end
         end
         ST_CWR:    state_in = dith ? ST_PRD : ST_OUT;
         ST_PRD:    state_in = ST_EVAL;
         ST_EVAL:   state_in = ST_RMW_RD;
         ST_RMW_RD: state_in = ST_RMW_WR;
         ST_RMW_WR: state_in = (slot_ff == 2'd3) ? ST_OUT : ST_RMW_RD;
         ST_OUT:    if (out_go) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      pal_we      = req_go && (req_data.operation == OP_LOAD)
                    && (32'(req_data.entry_index) < 32'(PALETTE_DEPTH));
      pal_waddr   = PA'(req_data.entry_index);
      pal_wdata   = {req_data.red, req_data.green, req_data.blue};
      pal_raddr   = (state_ff == ST_SRCH) ? PA'(srch_cnt_ff) : PA'(n_ff);

      cache_we    = 1'b0;
      cache_waddr = key_ff;
      cache_wdata = '0;
      cache_raddr = key_in;
      if (state_ff == ST_CLR) begin
         cache_we    = 1'b1;
         cache_waddr = clr_cnt_ff;
      end else if (state_ff == ST_CWR) begin
         cache_we    = 1'b1;
         cache_wdata = {1'b0, n_ff} + CACHE_DW'(1);
      end

      err_we    = 1'b0;
      err_waddr = slot_addr;
      err_wdata = '0;
      err_raddr = (state_ff == ST_ERD)
                  ? ((rowsel_ff ? EA'(ROWN) : EA'(0)) + EA'(pos)) : slot_addr;
      if (state_ff == ST_CLR) begin
         err_we    = (32'(clr_cnt_ff) < 32'(ED));
         err_waddr = EA'(clr_cnt_ff);
      end else if (state_ff == ST_ROWCLR) begin
         err_we    = 1'b1;
         err_waddr = (rowsel_ff ? EA'(0) : EA'(ROWN)) + EA'(clr_cnt_ff);
      end else if (state_ff == ST_RMW_WR) begin
         err_we = 1'b1;
         for (int c = 0; c < 3; c++) begin
            err_wdata[(2-c)*EW +: EW] = err_rdata[(2-c)*EW +: EW]
               + EW'(EW'(e_ff[c]) * $signed({1'b0, slot_weight}));
         end
      end
   end

   // datapath next values
   always_comb begin
      logic signed [EW:0]   t;
      logic signed [VW-1:0] v;
      logic signed [8:0]    diff;
      logic signed [8:0]    ed;
      logic [19:0]          sum;

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      reverse_in      = reverse_ff;
      rowsel_in       = rowsel_ff;
      clr_cnt_in      = clr_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      src_in          = src_ff;
      ch_in           = ch_ff;
      key_in          = key_ff;
      n_in            = n_ff;
      e_in            = e_ff;
      slot_in         = slot_ff;
      srch_cnt_in     = srch_cnt_ff;
      p1_valid_in     = 1'b0;
      p1_idx_in       = p1_idx_ff;
      d_valid_in      = 1'b0;
      d_idx_in        = d_idx_ff;
      dist_in         = dist_ff;
      best_in         = best_ff;
      sum             = '0;
      t               = '0;
      v               = '0;
      diff            = '0;
      ed              = '0;

      case (state_ff)
         // clearing sweeps
         ST_CLR, ST_ROWCLR: begin
            clr_cnt_in = clr_cnt_ff + CACHE_AW'(1);
         end
         // request intake
         ST_IDLE: begin
            clr_cnt_in = '0;
            if (req_go) begin
               src_in[0] = req_data.red;
               src_in[1] = req_data.green;
               src_in[2] = req_data.blue;
               if (req_data.operation == OP_START) begin
                  column_count_in = '0;
                  row_count_in    = '0;
                  reverse_in      = 1'b0;
                  rowsel_in       = 1'b0;
               end
            end
         end
         // add scaled error, clamp, form cache key
         ST_EADJ: begin
            for (int c = 0; c < 3; c++) begin
               t = dith ? {err_rdata[(3-c)*EW-1], err_rdata[(2-c)*EW +: EW]}
                        : '0;
               t = t + (EW+1)'(8);
               t = t >>> 4;
               v = VW'({1'b0, src_ff[c]}) + VW'(t);
               if (v < 0) ch_in[c] = 8'd0;
               else if (v > VW'(255)) ch_in[c] = 8'd255;
               else ch_in[c] = v[7:0];
            end
            key_in = {ch_in[0][7:3], ch_in[1][7:3], ch_in[2][7:3]};
         end
         // cache lookup result
         ST_CRD: begin
            n_in        = 8'(cache_rdata - CACHE_DW'(1));
            srch_cnt_in = '0;
            best_in     = BEST_INIT;
            if (cache_rdata == '0) n_in = '0;
         end
         // nearest colour search: read, distance, compare
         ST_SRCH: begin
            if (srch_cnt_ff != ps_eff) begin
               srch_cnt_in = srch_cnt_ff + PI'(1);
               p1_valid_in = 1'b1;
               p1_idx_in   = 8'(srch_cnt_ff);
            end
            if (p1_valid_ff) begin
               for (int c = 0; c < 3; c++) begin
                  diff = $signed({1'b0, ch_ff[c]})
                         - $signed({1'b0, pal_rdata[(2-c)*8 +: 8]});
                  sum  = sum + 20'(18'(diff * diff));
               end
               dist_in    = sum;
               d_valid_in = 1'b1;
               d_idx_in   = p1_idx_ff;
            end
            if (d_valid_ff && dist_ff < best_ff) begin
               best_in = dist_ff;
               n_in    = d_idx_ff;
            end
         end
         // limited error of the chosen colour
         ST_EVAL: begin
            slot_in = '0;
            for (int c = 0; c < 3; c++) begin
               ed = $signed({1'b0, ch_ff[c]})
                    - $signed({1'b0, pal_rdata[(2-c)*8 +: 8]});
               if (ed > 9'sd0 + 9'(ERROR_LIMIT)) e_in[c] = 9'(ERROR_LIMIT);
               else if (ed < -(9'(ERROR_LIMIT))) e_in[c] = -(9'(ERROR_LIMIT));
               else e_in[c] = ed;
            end
         end
         ST_RMW_WR: begin
            slot_in = slot_ff + 2'd1;
         end
         // result register and position counters
         ST_OUT: begin
            if (out_go) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.palette_index = n_ff;
               rsp_data_in.column        = 10'(phys);
               rsp_data_in.row_end       = last;
               rsp_data_in.image_end     = 1'b0;
               if (last) begin
                  row_count_in          = row_count_ff + 16'd1;
                  rsp_data_in.image_end = (row_count_in == image_height_ff);
                  column_count_in       = '0;
                  if (dith) begin
                     reverse_in = !reverse_ff;
                     rowsel_in  = !rowsel_ff;
                  end
               end else begin
                  column_count_in = CW'(col + PW'(1));
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLR;
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         reverse_ff       <= 1'b0;
         rowsel_ff        <= 1'b0;
         clr_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
         p1_valid_ff      <= 1'b0;
         d_valid_ff       <= 1'b0;
         image_width_ff   <= 11'd1;
         image_height_ff  <= 16'd1;
         palette_size_ff  <= 9'd256;
         dither_enable_ff <= 1'b1;
      end else begin
         state_ff        <= state_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         reverse_ff      <= reverse_in;
         rowsel_ff       <= rowsel_in;
         clr_cnt_ff      <= clr_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
         p1_valid_ff     <= p1_valid_in;
         d_valid_ff      <= d_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_type'(csr_index))
               CSR_WIDTH:  image_width_ff   <= csr_data[10:0];
               CSR_HEIGHT: image_height_ff  <= csr_data[15:0];
               CSR_PSIZE:  palette_size_ff  <= csr_data[8:0];
               CSR_DITHER: dither_enable_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      src_ff      <= src_in;
      ch_ff       <= ch_in;
      key_ff      <= key_in;
      n_ff        <= n_in;
      e_ff        <= e_in;
      slot_ff     <= slot_in;
      srch_cnt_ff <= srch_cnt_in;
      p1_idx_ff   <= p1_idx_in;
      d_idx_ff    <= d_idx_in;
      dist_ff     <= dist_in;
      best_ff     <= best_in;
   end

   // a filled cache entry is never marked empty
   a_cache_fill : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CWR) |-> (cache_we && cache_wdata != '0))
      else $error("cache fill writes empty code");

   // image end only comes with a row end
   a_image_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.image_end || rsp_data_ff.row_end))
      else $error("image end without row end");

   // error update writes back to the address just read
   a_rmw_addr : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RMW_WR) |-> (err_we && err_waddr == $past(err_raddr)))
      else $error("error row update address mismatch");

endmodule

`default_nettype wire
